// ----- rtl/star_surface_excision_mask_defines.svh -----
// Assertion macros shared by the star surface excision mask RTL
`ifndef STAR_SURFACE_EXCISION_MASK_DEFINES_SVH
`define STAR_SURFACE_EXCISION_MASK_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset
`define SSE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset
`define SSE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/sse_pkg.sv -----
// Types, constants and tables shared by the star surface excision mask
`default_nettype none
package sse_pkg;

   localparam int RAD_W  = 66;  // radicand of the square root
   localparam int ROOT_W = 33;
   localparam int REM_W  = 35;
   localparam int SQ_STEPS = 33;
   localparam int CR_W = 38;    // CORDIC x/y datapath
   localparam int ZW   = 33;    // CORDIC angle accumulator, Q30
   localparam int ANG_W = 19;   // Q3.16 angle

   localparam logic [33:0] Q30_HALF_PI = 34'd1686629713;
   localparam logic [33:0] Q30_PI      = 34'd3373259426;
   localparam logic [33:0] Q30_TWO_PI  = 34'd6746518852;

   localparam logic [30:0] ATAN_Q30 [32] = '{
      31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
      31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
      31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536, 31'd32768,
      31'd16384, 31'd8192, 31'd4096, 31'd2048, 31'd1024, 31'd512, 31'd256,
      31'd128, 31'd64, 31'd32, 31'd16, 31'd8, 31'd4, 31'd2, 31'd1, 31'd0
   };

   typedef enum logic [2:0] {
      CSR_ACTIVE    = 3'd0,
      CSR_CENTRE_X  = 3'd1,
      CSR_CENTRE_Y  = 3'd2,
      CSR_CENTRE_Z  = 3'd3,
      CSR_POL_START = 3'd4,
      CSR_AZI_START = 3'd5,
      CSR_POL_SCALE = 3'd6,
      CSR_AZI_SCALE = 3'd7
   } csr_index_type;

   // Side data that travels with each beat down the pipe
   typedef struct packed {
      logic        vld;
      logic        load;
      logic        fixed;   // result settled early
      logic        f_exc;
      logic        f_err;
      logic [5:0]  ent_pi;
      logic [6:0]  ent_bi;
      logic [31:0] ent_rad;
      logic [65:0] s3;
      logic [31:0] ux;
      logic [31:0] uy;
      logic [31:0] uz;
      logic        nx;
      logic        ny;
      logic        nz;
      logic        py0;
      logic        px0;
      logic        ay0;
      logic        ax0;
   } ctl_type;

endpackage
`default_nettype wire

// ----- rtl/sse_sqrt_cell.sv -----
// One restoring square-root cell: settles one root bit per clock while en is high
`default_nettype none
module sse_sqrt_cell (
   input  logic                             clock,
   input  logic                             en,
   input  logic [sse_pkg::REM_W-1:0]        rem_cur,
   input  logic [sse_pkg::ROOT_W-1:0]       root_cur,
   input  logic [sse_pkg::RAD_W-1:0]        rad_cur,
   output logic [sse_pkg::REM_W-1:0]        rem_ff,
   output logic [sse_pkg::ROOT_W-1:0]       root_ff,
   output logic [sse_pkg::RAD_W-1:0]        rad_ff
);

   logic [sse_pkg::REM_W+1:0]  rem_sh;
   logic [sse_pkg::REM_W+1:0]  trial;
   logic [sse_pkg::REM_W-1:0]  rem_in;
   logic [sse_pkg::ROOT_W-1:0] root_in;
   logic [sse_pkg::RAD_W-1:0]  rad_in;

   always_comb begin
      rem_sh = {rem_cur, rad_cur[sse_pkg::RAD_W-1 -: 2]};
      trial  = {2'b00, root_cur, 2'b01};
      rad_in = {rad_cur[sse_pkg::RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         rem_in  = sse_pkg::REM_W'(rem_sh - trial);
         root_in = {root_cur[sse_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = sse_pkg::REM_W'(rem_sh);
         root_in = {root_cur[sse_pkg::ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/sse_cordic_cell.sv -----
// One vectoring CORDIC micro-rotation, registered
`default_nettype none
module sse_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [sse_pkg::CR_W-1:0]   x_cur,
   input  logic signed [sse_pkg::CR_W-1:0]   y_cur,
   input  logic signed [sse_pkg::ZW-1:0]     z_cur,
   output logic signed [sse_pkg::CR_W-1:0]   x_ff,
   output logic signed [sse_pkg::CR_W-1:0]   y_ff,
   output logic signed [sse_pkg::ZW-1:0]     z_ff
);

   logic signed [sse_pkg::CR_W-1:0] xs;
   logic signed [sse_pkg::CR_W-1:0] ys;
   logic signed [sse_pkg::ZW-1:0]   ang;
   logic signed [sse_pkg::CR_W-1:0] x_in;
   logic signed [sse_pkg::CR_W-1:0] y_in;
   logic signed [sse_pkg::ZW-1:0]   z_in;

   always_comb begin
      xs  = x_cur >>> STEP;
      ys  = y_cur >>> STEP;
      ang = signed'(sse_pkg::ZW'(sse_pkg::ATAN_Q30[STEP]));
      // rotate toward the x axis
      if (!y_cur[sse_pkg::CR_W-1]) begin
         x_in = x_cur + ys;
         y_in = y_cur - xs;
         z_in = z_cur + ang;
      end else begin
         x_in = x_cur - ys;
         y_in = y_cur + xs;
         z_in = z_cur - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/star_surface_excision_mask.sv -----
// Top level of the star surface excision mask pipeline
// Usage:
//  req_* carries one beat per item: req_tuser = 0 loads one radius entry
//  (already scaled by the excision margin), req_tuser = 1 classifies a point.
//  Each classify beat yields exactly one rsp_* beat {index_error, excised};
//  load beats yield none. Results leave in input order.
//  From the accepting edge to rsp_tvalid a beat passes the offset register,
//  the square and sum registers, 33 square-root cells, one CORDIC setup
//  stage, one CORDIC cell per step, then angle rounding, scaling, index,
//  table read, radius square and the output register.
//  Throughput is one beat per clock while the pipe is not held; the radius
//  table is a single-port memory read every beat and written for loads,
//  at a fixed stage, so loads and classifies keep their order.
//  The csr_* port writes registers by index; write it only while idle.
//  Reset (synchronous, active high) empties the pipe and restores register
//  defaults; the radius table is undefined until loaded.
//  When rsp_tready is low with a result waiting, the whole pipe holds and
//  req_tready drops in the same cycle.
`default_nettype none
`include "star_surface_excision_mask_defines.svh"
module star_surface_excision_mask #(
   parameter int MAX_POLAR    = 64,
   parameter int MAX_AZIMUTH  = 128,
   parameter int CORDIC_STEPS = 20
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // point_x, point_y, point_z, entry_polar_index, entry_azimuth_index,
   // entry_radius, zero fill
   input  logic [143:0] req_tdata,
   // req_type
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // excised, index_error, zero fill
   output logic [7:0]   rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);

   localparam int DEPTH = MAX_POLAR * MAX_AZIMUTH;
   localparam int AW = $clog2(DEPTH);
   localparam int PW = $clog2(MAX_POLAR);
   localparam int BW = $clog2(MAX_AZIMUTH);
   localparam int NS = sse_pkg::SQ_STEPS;
   localparam int CW = sse_pkg::CR_W;
   localparam int ZW = sse_pkg::ZW;

   // configuration
   logic               active_ff;
   logic signed [31:0] centre_x_ff, centre_y_ff, centre_z_ff;
   logic [18:0]        pol_start_ff, azi_start_ff;
   logic [23:0]        pol_scale_ff, azi_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         centre_x_ff  <= '0;
         centre_y_ff  <= '0;
         centre_z_ff  <= '0;
         pol_start_ff <= '0;
         azi_start_ff <= '0;
         pol_scale_ff <= 24'd65536;
         azi_scale_ff <= 24'd65536;
      end else if (csr_we) begin
         case (sse_pkg::csr_index_type'(csr_addr))
            sse_pkg::CSR_ACTIVE:    active_ff    <= csr_wdata[0];
            sse_pkg::CSR_CENTRE_X:  centre_x_ff  <= signed'(csr_wdata);
            sse_pkg::CSR_CENTRE_Y:  centre_y_ff  <= signed'(csr_wdata);
            sse_pkg::CSR_CENTRE_Z:  centre_z_ff  <= signed'(csr_wdata);
            sse_pkg::CSR_POL_START: pol_start_ff <= csr_wdata[18:0];
            sse_pkg::CSR_AZI_START: azi_start_ff <= csr_wdata[18:0];
            sse_pkg::CSR_POL_SCALE: pol_scale_ff <= csr_wdata[23:0];
            sse_pkg::CSR_AZI_SCALE: azi_scale_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic rsp_tvalid_ff;
   logic [1:0] rsp_data_ff;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff[1], rsp_data_ff[0]};

   // stage 0: offsets from the centre
   logic signed [32:0] dx, dy, dz;
   sse_pkg::ctl_type   c0_in, c0_ff, c1_ff, c2_ff, c3_in, c3_ff;

   always_comb begin
      dx = 33'(signed'(req_tdata[31:0]))  - 33'(centre_x_ff);
      dy = 33'(signed'(req_tdata[63:32])) - 33'(centre_y_ff);
      dz = 33'(signed'(req_tdata[95:64])) - 33'(centre_z_ff);
      c0_in         = '0;
      c0_in.vld     = req_tvalid;
      c0_in.load    = !req_tuser;
      c0_in.fixed   = !active_ff || (dx == '0 && dy == '0 && dz == '0);
      c0_in.f_exc   = active_ff && (dx == '0 && dy == '0 && dz == '0);
      c0_in.f_err   = 1'b0;
      c0_in.ent_pi  = req_tdata[101:96];
      c0_in.ent_bi  = req_tdata[108:102];
      c0_in.ent_rad = req_tdata[140:109];
      c0_in.nx      = dx[32];
      c0_in.ny      = dy[32];
      c0_in.nz      = dz[32];
      c0_in.ux      = dx[32] ? 32'(-dx) : dx[31:0];
      c0_in.uy      = dy[32] ? 32'(-dy) : dy[31:0];
      c0_in.uz      = dz[32] ? 32'(-dz) : dz[31:0];
   end

   // stages 1 to 3: squares and sums
   logic [63:0] mx_ff, my_ff, mz_ff, mz2_ff;
   logic [64:0] sxy2_ff, sxy3_ff;

   always_comb begin
      c3_in    = c2_ff;
      c3_in.s3 = {1'b0, sxy2_ff} + {2'b00, mz2_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_ff.vld <= 1'b0;
         c1_ff.vld <= 1'b0;
         c2_ff.vld <= 1'b0;
         c3_ff.vld <= 1'b0;
      end else if (en) begin
         c0_ff <= c0_in;
         c1_ff <= c0_ff;
         c2_ff <= c1_ff;
         c3_ff <= c3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff   <= c0_ff.ux * c0_ff.ux;
         my_ff   <= c0_ff.uy * c0_ff.uy;
         mz_ff   <= c0_ff.uz * c0_ff.uz;
         sxy2_ff <= {1'b0, mx_ff} + {1'b0, my_ff};
         mz2_ff  <= mz_ff;
         sxy3_ff <= sxy2_ff;
      end
   end

   // square-root cell row
   logic [sse_pkg::REM_W-1:0]  rem_w  [0:NS];
   logic [sse_pkg::ROOT_W-1:0] root_w [0:NS];
   logic [sse_pkg::RAD_W-1:0]  rad_w  [0:NS];
   sse_pkg::ctl_type           sq_ctl_ff [0:NS-1];

   assign rem_w[0]  = '0;
   assign root_w[0] = '0;
   assign rad_w[0]  = {1'b0, sxy3_ff};

   for (genvar g = 0; g < NS; g++) begin : g_sq
      sse_sqrt_cell u_cell (
         .clock    (clock),
         .en       (en),
         .rem_cur  (rem_w[g]),
         .root_cur (root_w[g]),
         .rad_cur  (rad_w[g]),
         .rem_ff   (rem_w[g+1]),
         .root_ff  (root_w[g+1]),
         .rad_ff   (rad_w[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) sq_ctl_ff[k].vld <= 1'b0;
      end else if (en) begin
         sq_ctl_ff[0] <= c3_ff;
         for (int k = 1; k < NS; k++) sq_ctl_ff[k] <= sq_ctl_ff[k-1];
      end
   end

   // CORDIC setup
   sse_pkg::ctl_type cp_in, cp_ff;
   logic signed [CW-1:0] cp_px_ff, cp_py_ff, cp_ax_ff, cp_ay_ff;

   always_comb begin
      cp_in     = sq_ctl_ff[NS-1];
      cp_in.py0 = (root_w[NS] == '0);
      cp_in.px0 = (cp_in.uz == '0);
      cp_in.ay0 = (cp_in.uy == '0);
      cp_in.ax0 = (cp_in.ux == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) cp_ff.vld <= 1'b0;
      else if (en) cp_ff <= cp_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cp_px_ff <= signed'(CW'(sq_ctl_ff[NS-1].uz));
         cp_py_ff <= signed'(CW'(root_w[NS]));
         cp_ax_ff <= signed'(CW'(sq_ctl_ff[NS-1].ux));
         cp_ay_ff <= signed'(CW'(sq_ctl_ff[NS-1].uy));
      end
   end

   // CORDIC cell rows, polar and azimuth side by side
   logic signed [CW-1:0] pxw [0:CORDIC_STEPS];
   logic signed [CW-1:0] pyw [0:CORDIC_STEPS];
   logic signed [ZW-1:0] pzw [0:CORDIC_STEPS];
   logic signed [CW-1:0] axw [0:CORDIC_STEPS];
   logic signed [CW-1:0] ayw [0:CORDIC_STEPS];
   logic signed [ZW-1:0] azw [0:CORDIC_STEPS];
   sse_pkg::ctl_type     cr_ctl_ff [0:CORDIC_STEPS-1];

   assign pxw[0] = cp_px_ff;
   assign pyw[0] = cp_py_ff;
   assign pzw[0] = '0;
   assign axw[0] = cp_ax_ff;
   assign ayw[0] = cp_ay_ff;
   assign azw[0] = '0;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cr
      sse_cordic_cell #(.STEP(g)) u_pol (
         .clock (clock), .en (en),
         .x_cur (pxw[g]), .y_cur (pyw[g]), .z_cur (pzw[g]),
         .x_ff  (pxw[g+1]), .y_ff (pyw[g+1]), .z_ff (pzw[g+1])
      );
      sse_cordic_cell #(.STEP(g)) u_azi (
         .clock (clock), .en (en),
         .x_cur (axw[g]), .y_cur (ayw[g]), .z_cur (azw[g]),
         .x_ff  (axw[g+1]), .y_ff (ayw[g+1]), .z_ff (azw[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CORDIC_STEPS; k++) cr_ctl_ff[k].vld <= 1'b0;
      end else if (en) begin
         cr_ctl_ff[0] <= cp_ff;
         for (int k = 1; k < CORDIC_STEPS; k++) cr_ctl_ff[k] <= cr_ctl_ff[k-1];
      end
   end

   // clamp, place in quadrant, round to Q3.16
   function automatic logic [18:0] to_q16(input logic y0, input logic x0,
                                          input logic signed [ZW-1:0] z,
                                          input logic xneg, input logic yneg);
      logic [33:0] a;
      logic [33:0] r;
      if (y0) a = '0;
      else if (x0) a = sse_pkg::Q30_HALF_PI;
      else if (z[ZW-1]) a = '0;
      else if ({1'b0, z} > sse_pkg::Q30_HALF_PI) a = sse_pkg::Q30_HALF_PI;
      else a = {1'b0, z};
      if (xneg && !yneg) a = sse_pkg::Q30_PI - a;
      else if (xneg) a = sse_pkg::Q30_PI + a;
      else if (yneg) a = sse_pkg::Q30_TWO_PI - a;
      if (a >= sse_pkg::Q30_TWO_PI) a = a - sse_pkg::Q30_TWO_PI;
      r = a + 34'd8192;
      return r[32:14];
   endfunction

   sse_pkg::ctl_type pt_ctl_ff, pr_ctl_ff;
   logic [18:0]      pt_pang_ff, pt_aang_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_ctl_ff.vld <= 1'b0;
         pr_ctl_ff.vld <= 1'b0;
      end else if (en) begin
         pt_ctl_ff <= cr_ctl_ff[CORDIC_STEPS-1];
         pr_ctl_ff <= pt_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pt_pang_ff <= to_q16(cr_ctl_ff[CORDIC_STEPS-1].py0,
                              cr_ctl_ff[CORDIC_STEPS-1].px0, pzw[CORDIC_STEPS],
                              cr_ctl_ff[CORDIC_STEPS-1].nz, 1'b0);
         pt_aang_ff <= to_q16(cr_ctl_ff[CORDIC_STEPS-1].ay0,
                              cr_ctl_ff[CORDIC_STEPS-1].ax0, azw[CORDIC_STEPS],
                              cr_ctl_ff[CORDIC_STEPS-1].nx,
                              cr_ctl_ff[CORDIC_STEPS-1].ny);
      end
   end

   // (angle - start) * scale
   logic signed [19:0] pdiff, adiff;
   logic signed [44:0] pprod_ff, aprod_ff;

   always_comb begin
      pdiff = signed'({1'b0, pt_pang_ff}) - signed'({1'b0, pol_start_ff});
      adiff = signed'({1'b0, pt_aang_ff}) - signed'({1'b0, azi_start_ff});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pprod_ff <= 45'(pdiff) * 45'(signed'({1'b0, pol_scale_ff}));
         aprod_ff <= 45'(adiff) * 45'(signed'({1'b0, azi_scale_ff}));
      end
   end

   // round to indices, range check, form the table address
   logic [45:0]      psum, asum;
   logic [13:0]      pidx, aidx;
   logic             cls_ok, ld_ok;
   logic [PW-1:0]    sel_p;
   logic [BW-1:0]    sel_b;
   sse_pkg::ctl_type ix_in, ix_ctl_ff;
   logic             ix_we_ff;
   logic [AW-1:0]    ix_addr_ff;

   always_comb begin
      psum   = 46'(pprod_ff) + 46'd2147483648;
      asum   = 46'(aprod_ff) + 46'd2147483648;
      pidx   = psum[45:32];
      aidx   = asum[45:32];
      cls_ok = !pidx[13] && (pidx[12:0] < 13'(MAX_POLAR)) &&
               !aidx[13] && (aidx[12:0] < 13'(MAX_AZIMUTH));
      ld_ok  = (32'(pr_ctl_ff.ent_pi) < 32'(MAX_POLAR)) &&
               (32'(pr_ctl_ff.ent_bi) < 32'(MAX_AZIMUTH));
      if (pr_ctl_ff.load) begin
         sel_p = PW'(pr_ctl_ff.ent_pi);
         sel_b = BW'(pr_ctl_ff.ent_bi);
      end else begin
         sel_p = PW'(pidx[12:0]);
         sel_b = BW'(aidx[12:0]);
      end
      ix_in = pr_ctl_ff;
      if (!pr_ctl_ff.load && !pr_ctl_ff.fixed && !cls_ok) begin
         ix_in.fixed = 1'b1;
         ix_in.f_err = 1'b1;
         ix_in.f_exc = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ix_ctl_ff.vld <= 1'b0;
         ix_we_ff      <= 1'b0;
      end else if (en) begin
         ix_ctl_ff <= ix_in;
         ix_we_ff  <= pr_ctl_ff.vld && pr_ctl_ff.load && ld_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (en) ix_addr_ff <= AW'(AW'(sel_b) * AW'(MAX_POLAR) + AW'(sel_p));
   end

   // radius table: one address per beat, read every beat, also written for loads
   logic [31:0]      radius_mem [0:DEPTH-1];
   logic [31:0]      rd_data_ff;
   sse_pkg::ctl_type rd_ctl_ff, mq_ctl_ff;
   logic [63:0]      rr_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (ix_we_ff) radius_mem[ix_addr_ff] <= ix_ctl_ff.ent_rad;
         rd_data_ff <= radius_mem[ix_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ctl_ff.vld <= 1'b0;
         mq_ctl_ff.vld <= 1'b0;
      end else if (en) begin
         rd_ctl_ff <= ix_ctl_ff;
         mq_ctl_ff <= rd_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) rr_ff <= rd_data_ff * rd_data_ff;
   end

   // output register
   logic rsp_exc;

   always_comb begin
      if (mq_ctl_ff.fixed) rsp_exc = mq_ctl_ff.f_exc;
      else rsp_exc = (mq_ctl_ff.s3 < {2'b00, rr_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid_ff <= 1'b0;
      else if (en) rsp_tvalid_ff <= mq_ctl_ff.vld && !mq_ctl_ff.load;
   end

   always_ff @(posedge clock) begin
      if (en) rsp_data_ff <= {mq_ctl_ff.fixed && mq_ctl_ff.f_err, rsp_exc};
   end

   `SSE_ASSERT_NOW(a_err_not_exc, rsp_tvalid, !(rsp_tdata[0] && rsp_tdata[1]), "excised with index error")
   `SSE_ASSERT_NOW(a_wr_in_range, ix_we_ff, (32'(ix_addr_ff) < 32'(DEPTH)), "table write out of range")
   `SSE_ASSERT_NOW(a_wr_is_load, ix_we_ff, (ix_ctl_ff.vld && ix_ctl_ff.load), "table write without load")
   `SSE_ASSERT_NEXT(a_load_silent, (en && mq_ctl_ff.vld && mq_ctl_ff.load), !rsp_tvalid, "load produced a result")

endmodule
`default_nettype wire
